[rtl/efc_pkg.sv]
// Shared types, codes and defaults for the escape-time fractal counter.
`timescale 1ns / 1ps

package efc_pkg;

    localparam int COORD_WIDTH_DEF   = 32;
    localparam int FRACTION_BITS_DEF = 28;
    localparam int COUNT_WIDTH_DEF   = 16;

    localparam int          CFG_INDEX_WIDTH = 8;
    localparam logic [31:0] LIMIT_RESET     = 32'd256;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_MODE   = CFG_INDEX_WIDTH'(0);
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_LIMIT  = CFG_INDEX_WIDTH'(1);
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_JULIA_RE = CFG_INDEX_WIDTH'(2);
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_JULIA_IM = CFG_INDEX_WIDTH'(3);

    localparam logic [1:0] MODE_MANDELBROT = 2'd0;
    localparam logic [1:0] MODE_JULIA      = 2'd1;
    localparam logic [1:0] MODE_SHIP       = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_UPD,
        S_FIN
    } t_state;

    typedef struct packed {
        logic load;
        logic mul;
        logic upd;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic at_limit;
        logic escaped;
        logic out_free;
    } t_dp_status;

endpackage

[rtl/escape_time_fractal_counter.sv]
// Top level of the escape-time fractal counter (Mandelbrot, Julia, Burning Ship).
//
//  channel   direction  handshake                 payload
//  s_axis    in         s_axis_tvalid/tready      tdata: point_real, point_imag
//  m_axis    out        m_axis_tvalid/tready      tdata: escape_count
//  cfg       in         i_cfg_valid/o_cfg_ready   i_cfg_index, i_cfg_data
//
// One point at a time; each iteration multiplies into the product registers, then
// updates the coordinates, until the iteration limit stops the point or it escapes.
// Synchronous active-low reset clears the controller, output valid and configuration registers.
// A result waits in the output register; a new point is taken meanwhile, and the
// next result holds in the controller until the output register frees up.
`timescale 1ns / 1ps

module escape_time_fractal_counter #(
    parameter int COORD_WIDTH   = efc_pkg::COORD_WIDTH_DEF,
    parameter int FRACTION_BITS = efc_pkg::FRACTION_BITS_DEF,
    parameter int COUNT_WIDTH   = efc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // point_real, point_imag (low to high), zero padded to bytes
    input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]  s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // escape_count, zero padded to bytes
    output logic [((COUNT_WIDTH+7)/8)*8-1:0]    m_axis_tdata,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [efc_pkg::CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  logic [((COORD_WIDTH > COUNT_WIDTH) ? COORD_WIDTH : COUNT_WIDTH)-1:0] i_cfg_data
);
    import efc_pkg::*;

    localparam int CFG_DATA_WIDTH = (COORD_WIDTH > COUNT_WIDTH) ? COORD_WIDTH : COUNT_WIDTH;
    localparam int OUT_WIDTH      = ((COUNT_WIDTH + 7) / 8) * 8;

    logic [1:0]                    mode;
    logic [COUNT_WIDTH-1:0]        limit;
    logic signed [COORD_WIDTH-1:0] julia_re;
    logic signed [COORD_WIDTH-1:0] julia_im;
    logic [COUNT_WIDTH-1:0]        count;
    t_dp_cmd                       cmd;
    t_dp_status                    status;

    assign o_cfg_ready = i_rst_n;

    efc_cfg #(
        .COORD_WIDTH (COORD_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH),
        .DATA_WIDTH  (CFG_DATA_WIDTH)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_cfg_valid),
        .i_index    (i_cfg_index),
        .i_data     (i_cfg_data),
        .o_mode     (mode),
        .o_limit    (limit),
        .o_julia_re (julia_re),
        .o_julia_im (julia_im)
    );

    efc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    efc_dp #(
        .COORD_WIDTH   (COORD_WIDTH),
        .FRACTION_BITS (FRACTION_BITS),
        .COUNT_WIDTH   (COUNT_WIDTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_status   (status),
        .i_point_re ($signed(s_axis_tdata[COORD_WIDTH-1:0])),
        .i_point_im ($signed(s_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH])),
        .i_mode     (mode),
        .i_limit    (limit),
        .i_julia_re (julia_re),
        .i_julia_im (julia_im),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_count    (count)
    );

    assign m_axis_tdata = OUT_WIDTH'(count);

endmodule

[rtl/efc_cfg.sv]
// Configuration register file: mode, iteration limit and Julia constant.
`timescale 1ns / 1ps

module efc_cfg #(
    parameter int COORD_WIDTH = efc_pkg::COORD_WIDTH_DEF,
    parameter int COUNT_WIDTH = efc_pkg::COUNT_WIDTH_DEF,
    parameter int DATA_WIDTH  = efc_pkg::COORD_WIDTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    input  logic [efc_pkg::CFG_INDEX_WIDTH-1:0]  i_index,
    input  logic [DATA_WIDTH-1:0]                i_data,
    output logic [1:0]                           o_mode,
    output logic [COUNT_WIDTH-1:0]               o_limit,
    output logic signed [COORD_WIDTH-1:0]        o_julia_re,
    output logic signed [COORD_WIDTH-1:0]        o_julia_im
);
    import efc_pkg::*;

    logic [1:0]                    r_mode;
    logic [COUNT_WIDTH-1:0]        r_limit;
    logic signed [COORD_WIDTH-1:0] r_julia_re;
    logic signed [COORD_WIDTH-1:0] r_julia_im;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_MANDELBROT;
            r_limit    <= LIMIT_RESET[COUNT_WIDTH-1:0];
            r_julia_re <= '0;
            r_julia_im <= '0;
        end else if (i_valid) begin
            case (i_index)
                REG_MODE:     r_mode     <= i_data[1:0];
                REG_LIMIT:    r_limit    <= i_data[COUNT_WIDTH-1:0];
                REG_JULIA_RE: r_julia_re <= $signed(i_data[COORD_WIDTH-1:0]);
                REG_JULIA_IM: r_julia_im <= $signed(i_data[COORD_WIDTH-1:0]);
                default: ;
            endcase
        end
    end

    assign o_mode     = r_mode;
    assign o_limit    = r_limit;
    assign o_julia_re = r_julia_re;
    assign o_julia_im = r_julia_im;

endmodule

[rtl/efc_ctrl.sv]
// Controller state machine sequencing load, multiply, update and result hand-off.
`timescale 1ns / 1ps

module efc_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  efc_pkg::t_dp_status i_status,
    output efc_pkg::t_dp_cmd    o_cmd
);
    import efc_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = i_rst_n;
                if (i_rst_n && i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MUL;
                end
            end
            S_MUL: begin
                if (i_status.at_limit) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.mul = 1'b1;
                    n_state   = S_UPD;
                end
            end
            S_UPD: begin
                if (i_status.escaped) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.upd = 1'b1;
                    n_state   = S_MUL;
                end
            end
            S_FIN: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

[rtl/efc_dp.sv]
// Datapath: coordinate registers, product registers, update logic, output register.
`timescale 1ns / 1ps

module efc_dp #(
    parameter int COORD_WIDTH   = efc_pkg::COORD_WIDTH_DEF,
    parameter int FRACTION_BITS = efc_pkg::FRACTION_BITS_DEF,
    parameter int COUNT_WIDTH   = efc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  efc_pkg::t_dp_cmd              i_cmd,
    output efc_pkg::t_dp_status           o_status,
    input  logic signed [COORD_WIDTH-1:0] i_point_re,
    input  logic signed [COORD_WIDTH-1:0] i_point_im,
    input  logic [1:0]                    i_mode,
    input  logic [COUNT_WIDTH-1:0]        i_limit,
    input  logic signed [COORD_WIDTH-1:0] i_julia_re,
    input  logic signed [COORD_WIDTH-1:0] i_julia_im,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [COUNT_WIDTH-1:0]        o_count
);
    import efc_pkg::*;

    localparam int W  = COORD_WIDTH;
    localparam int PW = 2 * COORD_WIDTH;

    localparam logic [PW:0] ESC_LIMIT = {{PW{1'b0}}, 1'b1} << (2 * FRACTION_BITS + 2);
    localparam logic signed [W-1:0] C_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] C_MIN = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [PW+1:0] X_MAX = {{(W+2){1'b0}}, C_MAX};
    localparam logic signed [PW+1:0] X_MIN = {{(W+2){1'b1}}, C_MIN};

    function automatic logic signed [W-1:0] sat(input logic signed [PW+1:0] v);
        logic signed [W-1:0] r;
        if (v > X_MAX) begin
            r = C_MAX;
        end else if (v < X_MIN) begin
            r = C_MIN;
        end else begin
            r = v[W-1:0];
        end
        return r;
    endfunction

    logic signed [W-1:0]    r_x, r_y, r_cr, r_ci;
    logic signed [PW-1:0]   r_xx, r_yy, r_xy;
    logic [COUNT_WIDTH-1:0] r_count;
    logic                   r_out_valid;
    logic [COUNT_WIDTH-1:0] r_out_count;

    logic                   julia;
    logic                   ship;
    logic [PW:0]            mag;
    logic signed [PW:0]     diff;
    logic signed [PW:0]     diff_sh;
    logic signed [PW:0]     xy_ext;
    logic signed [PW:0]     xy_abs;
    logic signed [PW:0]     twice_sh;
    logic signed [PW+1:0]   nx_wide;
    logic signed [PW+1:0]   ny_wide;

    assign julia = (i_mode == MODE_JULIA);
    assign ship  = (i_mode == MODE_SHIP);

    assign mag      = {1'b0, r_xx} + {1'b0, r_yy};
    assign diff     = {r_xx[PW-1], r_xx} - {r_yy[PW-1], r_yy};
    assign diff_sh  = diff >>> FRACTION_BITS;
    assign xy_ext   = {r_xy[PW-1], r_xy};
    assign xy_abs   = (ship && r_xy[PW-1]) ? -xy_ext : xy_ext;
    assign twice_sh = (xy_abs <<< 1) >>> FRACTION_BITS;
    assign nx_wide  = {diff_sh[PW], diff_sh} + {{(W+2){r_cr[W-1]}}, r_cr};
    assign ny_wide  = {twice_sh[PW], twice_sh} + {{(W+2){r_ci[W-1]}}, r_ci};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_count <= '0;
            if (julia) begin
                r_x  <= i_point_re;
                r_y  <= i_point_im;
                r_cr <= i_julia_re;
                r_ci <= i_julia_im;
            end else begin
                r_x  <= '0;
                r_y  <= '0;
                r_cr <= i_point_re;
                r_ci <= i_point_im;
            end
        end else if (i_cmd.upd) begin
            r_x     <= sat(nx_wide);
            r_y     <= sat(ny_wide);
            r_count <= r_count + COUNT_WIDTH'(1);
        end
        if (i_cmd.mul) begin
            r_xx <= PW'(r_x) * PW'(r_x);
            r_yy <= PW'(r_y) * PW'(r_y);
            r_xy <= PW'(r_x) * PW'(r_y);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_count <= r_count;
        end
    end

    assign o_status.at_limit = (r_count >= i_limit);
    assign o_status.escaped  = (mag >= ESC_LIMIT);
    assign o_status.out_free = !r_out_valid || i_ready;

    assign o_valid = r_out_valid;
    assign o_count = r_out_count;

endmodule

[rtl/efc_checker.sv]
// Port-level checker for the escape-time fractal counter, bound to the top level.
`timescale 1ns / 1ps

module efc_checker #(
    parameter int IN_WIDTH  = 64,
    parameter int OUT_WIDTH = 16
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_s_valid,
    input logic                 i_s_ready,
    input logic [IN_WIDTH-1:0]  i_s_data,
    input logic                 i_m_valid,
    input logic                 i_m_ready,
    input logic [OUT_WIDTH-1:0] i_m_data
);

    // one point in flight: no second request right after one is taken
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_valid && i_s_ready) |=> !i_s_ready)
        else $error("input accepted on consecutive cycles");

    // a result's valid must not rise too soon after its request is taken
    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_valid && i_s_ready) |=> !$rose(i_m_valid) ##1 !$rose(i_m_valid))
        else $error("result too soon after request");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_valid && !i_s_ready) |=> (i_s_valid && $stable(i_s_data)))
        else $error("request dropped or changed while waiting");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_valid && !i_m_ready) |=> (i_m_valid && $stable(i_m_data)))
        else $error("output dropped or changed while stalled");

    a_reset_clear: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_m_valid)
        else $error("output valid right after reset");

endmodule

bind escape_time_fractal_counter efc_checker #(
    .IN_WIDTH  (((2*COORD_WIDTH+7)/8)*8),
    .OUT_WIDTH (((COUNT_WIDTH+7)/8)*8)
) u_efc_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_s_valid (s_axis_tvalid),
    .i_s_ready (s_axis_tready),
    .i_s_data  (s_axis_tdata),
    .i_m_valid (m_axis_tvalid),
    .i_m_ready (m_axis_tready),
    .i_m_data  (m_axis_tdata)
);
